// ===== hw/rtl/fsc_pkg.sv =====
`default_nettype none

package fsc_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int COUNT_WIDTH   = 16;
  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int STEP_W = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int KIND_W       = 16;
  localparam int PROTO_W      = 8;
  localparam int FLAG_W       = 8;
  localparam int ICMP_W       = 8;
  localparam int ADDR_W       = 32;
  localparam int LIMIT_W      = 16;
  localparam int OUT_COUNT_W  = 16;
  localparam int ALERT_KIND_W = 2;
  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  // register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // header codes
  localparam logic [KIND_W-1:0]  IPV4_KIND     = 16'h0800;
  localparam logic [PROTO_W-1:0] TCP_PROTO     = 8'd6;
  localparam logic [PROTO_W-1:0] ICMP_PROTO    = 8'd1;
  localparam logic [FLAG_W-1:0]  TH_SYN        = 8'h02;
  localparam logic [ICMP_W-1:0]  ECHO_REQ_KIND = 8'd8;

  typedef enum logic [ALERT_KIND_W-1:0] {
    ALERT_SYN  = 2'd0,
    ALERT_ICMP = 2'd1,
    ALERT_DROP = 2'd2
  } alert_kind_t;

  typedef enum logic {
    REG_SYN_LIMIT  = 1'b0,
    REG_ECHO_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_BUMP,
    ST_SWEEP,
    ST_FLUSH
  } seq_state_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              has_free;
    logic [SLOT_W-1:0] free_slot;
  } cam_look_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
  } cam_alloc_t;

  typedef struct packed {
    logic                   we;
    logic [SLOT_W-1:0]      waddr;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [SLOT_W-1:0]      raddr;
  } ram_req_t;

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
    if (v == COUNT_MAX) begin
      return v;
    end
    return COUNT_WIDTH'(v + 1'b1);
  endfunction

  function automatic logic [OUT_COUNT_W-1:0] sat_out(input logic [COUNT_WIDTH-1:0] v);
    if (CMP_W'(v) > CMP_W'({OUT_COUNT_W{1'b1}})) begin
      return '1;
    end
    return OUT_COUNT_W'(v);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fsc_ram.sv =====
`default_nettype none

module fsc_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fsc_cam.sv =====
`default_nettype none

module fsc_cam (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [fsc_pkg::ADDR_W-1:0]    key,
  input  wire fsc_pkg::cam_alloc_t           alloc,
  input  wire logic [fsc_pkg::SLOT_W-1:0]    rd_slot,
  output fsc_pkg::cam_look_t                 look,
  output logic                               rd_used,
  output logic      [fsc_pkg::ADDR_W-1:0]    rd_addr
);

  import fsc_pkg::*;

  logic [ADDR_W-1:0]        slot_addr [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] slot_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else if (alloc.en) begin
      slot_used[alloc.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc.en) begin
      slot_addr[alloc.slot] <= alloc.addr;
    end
  end

  // parallel compare, lowest slot wins
  always_comb begin
    look = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_used[i]) begin
        if (slot_addr[i] == key) begin
          look.hit      = 1'b1;
          look.hit_slot = SLOT_W'(i);
        end
      end else begin
        look.has_free  = 1'b1;
        look.free_slot = SLOT_W'(i);
      end
    end
  end

  assign rd_used = slot_used[rd_slot];
  assign rd_addr = slot_addr[rd_slot];

endmodule

`default_nettype wire

// ===== hw/rtl/fsc_seq.sv =====
`default_nettype none

module fsc_seq (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              command,
  input  wire logic [fsc_pkg::KIND_W-1:0]        ether_kind,
  input  wire logic [fsc_pkg::PROTO_W-1:0]       ip_proto,
  input  wire logic [fsc_pkg::FLAG_W-1:0]        tcp_flag_bits,
  input  wire logic [fsc_pkg::ICMP_W-1:0]        icmp_kind,
  input  wire logic [fsc_pkg::ADDR_W-1:0]        source_addr,
  input  wire logic [fsc_pkg::LIMIT_W-1:0]       syn_limit,
  input  wire logic [fsc_pkg::LIMIT_W-1:0]       echo_limit,
  output logic                                   alert_strobe,
  output logic      [fsc_pkg::ALERT_KIND_W-1:0]  alert_kind,
  output logic      [fsc_pkg::ADDR_W-1:0]        alert_addr,
  output logic      [fsc_pkg::OUT_COUNT_W-1:0]   alert_count,
  output logic                                   last_alert,
  output logic      [fsc_pkg::ADDR_W-1:0]        cam_key,
  output fsc_pkg::cam_alloc_t                    cam_alloc,
  output logic      [fsc_pkg::SLOT_W-1:0]        cam_rd_slot,
  input  wire fsc_pkg::cam_look_t                cam_look,
  input  wire logic                              cam_rd_used,
  input  wire logic [fsc_pkg::ADDR_W-1:0]        cam_rd_addr,
  output fsc_pkg::ram_req_t                      syn_req,
  input  wire logic [fsc_pkg::COUNT_WIDTH-1:0]   syn_rdata,
  output fsc_pkg::ram_req_t                      echo_req,
  input  wire logic [fsc_pkg::COUNT_WIDTH-1:0]   echo_rdata
);

  import fsc_pkg::*;

  seq_state_t state, state_next;

  logic [ADDR_W-1:0] src, src_next;
  logic              is_syn, is_syn_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [STEP_W-1:0] step, step_next;
  logic              pass, pass_next;

  logic                   pend_valid, pend_valid_next;
  alert_kind_t            pend_kind, pend_kind_next;
  logic [ADDR_W-1:0]      pend_addr, pend_addr_next;
  logic [OUT_COUNT_W-1:0] pend_count, pend_count_next;

  logic                   alert_strobe_next;
  alert_kind_t            out_kind, out_kind_next;
  logic [ADDR_W-1:0]      alert_addr_next;
  logic [OUT_COUNT_W-1:0] alert_count_next;
  logic                   last_alert_next;

  logic                   pkt_syn, pkt_echo;
  logic                   issue, eval, fire;
  logic [STEP_W-1:0]      step_m1;
  logic [SLOT_W-1:0]      ev_slot;
  logic [COUNT_WIDTH-1:0] tally;
  logic [LIMIT_W-1:0]     limit;

  assign pkt_syn  = (ether_kind == IPV4_KIND) && (ip_proto == TCP_PROTO) &&
                    ((tcp_flag_bits & TH_SYN) != '0);
  assign pkt_echo = (ether_kind == IPV4_KIND) && (ip_proto == ICMP_PROTO) &&
                    (icmp_kind == ECHO_REQ_KIND);

  // sweep: read slot step, judge it in the following cycle as slot step-1
  assign issue   = step < STEP_W'(TABLE_ENTRIES);
  assign eval    = step != '0;
  assign step_m1 = STEP_W'(step - 1'b1);
  assign ev_slot = step_m1[SLOT_W-1:0];
  assign tally   = pass ? echo_rdata : syn_rdata;
  assign limit   = pass ? echo_limit : syn_limit;
  assign fire    = eval && cam_rd_used && (CMP_W'(tally) > CMP_W'(limit));

  assign busy        = state != ST_IDLE;
  assign cam_key     = src;
  assign cam_rd_slot = ev_slot;
  assign alert_kind  = out_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pend_valid   <= 1'b0;
      alert_strobe <= 1'b0;
    end else begin
      state        <= state_next;
      pend_valid   <= pend_valid_next;
      alert_strobe <= alert_strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    src         <= src_next;
    is_syn      <= is_syn_next;
    slot        <= slot_next;
    step        <= step_next;
    pass        <= pass_next;
    pend_kind   <= pend_kind_next;
    pend_addr   <= pend_addr_next;
    pend_count  <= pend_count_next;
    out_kind    <= out_kind_next;
    alert_addr  <= alert_addr_next;
    alert_count <= alert_count_next;
    last_alert  <= last_alert_next;
  end

  always_comb begin
    state_next        = state;
    src_next          = src;
    is_syn_next       = is_syn;
    slot_next         = slot;
    step_next         = step;
    pass_next         = pass;
    pend_valid_next   = pend_valid;
    pend_kind_next    = pend_kind;
    pend_addr_next    = pend_addr;
    pend_count_next   = pend_count;
    alert_strobe_next = 1'b0;
    out_kind_next     = out_kind;
    alert_addr_next   = alert_addr;
    alert_count_next  = alert_count;
    last_alert_next   = last_alert;
    cam_alloc         = '0;
    syn_req           = '0;
    echo_req          = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (command) begin
            step_next  = '0;
            pass_next  = 1'b0;
            state_next = ST_SWEEP;
          end else if (pkt_syn || pkt_echo) begin
            src_next    = source_addr;
            is_syn_next = pkt_syn;
            state_next  = ST_LOOK;
          end
        end
      end

      ST_LOOK: begin
        if (cam_look.hit) begin
          slot_next      = cam_look.hit_slot;
          syn_req.raddr  = cam_look.hit_slot;
          echo_req.raddr = cam_look.hit_slot;
          state_next     = ST_BUMP;
        end else if (cam_look.has_free) begin
          // new source: tallies start at zero plus this packet
          cam_alloc.en   = 1'b1;
          cam_alloc.slot = cam_look.free_slot;
          cam_alloc.addr = src;
          syn_req.we     = 1'b1;
          syn_req.waddr  = cam_look.free_slot;
          syn_req.wdata  = COUNT_WIDTH'(is_syn);
          echo_req.we    = 1'b1;
          echo_req.waddr = cam_look.free_slot;
          echo_req.wdata = COUNT_WIDTH'(!is_syn);
          state_next     = ST_IDLE;
        end else begin
          alert_strobe_next = 1'b1;
          out_kind_next     = ALERT_DROP;
          alert_addr_next   = src;
          alert_count_next  = '0;
          last_alert_next   = 1'b1;
          state_next        = ST_IDLE;
        end
      end

      ST_BUMP: begin
        if (is_syn) begin
          syn_req.we    = 1'b1;
          syn_req.waddr = slot;
          syn_req.wdata = bump(syn_rdata);
        end else begin
          echo_req.we    = 1'b1;
          echo_req.waddr = slot;
          echo_req.wdata = bump(echo_rdata);
        end
        state_next = ST_IDLE;
      end

      ST_SWEEP: begin
        if (issue) begin
          syn_req.raddr  = step[SLOT_W-1:0];
          echo_req.raddr = step[SLOT_W-1:0];
        end
        if (fire) begin
          if (pass) begin
            echo_req.we    = 1'b1;
            echo_req.waddr = ev_slot;
            echo_req.wdata = '0;
          end else begin
            syn_req.we    = 1'b1;
            syn_req.waddr = ev_slot;
            syn_req.wdata = '0;
          end
          // older alert goes out, new one waits to learn if it is the last
          if (pend_valid) begin
            alert_strobe_next = 1'b1;
            out_kind_next     = pend_kind;
            alert_addr_next   = pend_addr;
            alert_count_next  = pend_count;
            last_alert_next   = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_kind_next  = pass ? ALERT_ICMP : ALERT_SYN;
          pend_addr_next  = cam_rd_addr;
          pend_count_next = sat_out(tally);
        end
        if (issue) begin
          step_next = STEP_W'(step + 1'b1);
        end else if (!pass) begin
          pass_next = 1'b1;
          step_next = '0;
        end else begin
          state_next = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        if (pend_valid) begin
          alert_strobe_next = 1'b1;
          out_kind_next     = pend_kind;
          alert_addr_next   = pend_addr;
          alert_count_next  = pend_count;
          last_alert_next   = 1'b1;
        end
        pend_valid_next = 1'b0;
        state_next      = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/per_source_flood_counter_core.sv =====
// per-source flood counter: an item is a packet summary (command 0) or a sweep
// tick (command 1), taken on a clock edge with start high and busy low. ipv4
// tcp packets with syn set bump the source's syn tally, icmp echo requests its
// echo tally; tallies saturate. sources sit in a 32-slot fully associative
// table filled lowest free slot first and never freed. a packet that is not
// counted is taken with busy staying low; a new source holds busy through a
// lookup, a known source through a lookup and then a read-modify-write on the
// registered-read tally memories. a new source meeting a full table gives one
// drop result, in the cycle after the lookup. a tick walks the table twice,
// syn tallies then echo tallies, one slot a cycle through the tally memory
// read port, clearing each tally it reports; busy stays high through both
// walks and a final flush. results come out with a one-cycle alert_strobe and
// cannot be held off: catch them when they appear. last_alert marks the final
// result of an item; a quiet tick gives none. syn_limit (byte address 0) and
// echo_limit (byte address 4) reset to 100 and are to be written over the apb
// port by the user only while busy is low; the block does not enforce it.
`default_nettype none

module per_source_flood_counter_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // item port
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              command,
  input  wire logic [fsc_pkg::KIND_W-1:0]        ether_kind,
  input  wire logic [fsc_pkg::PROTO_W-1:0]       ip_proto,
  input  wire logic [fsc_pkg::FLAG_W-1:0]        tcp_flag_bits,
  input  wire logic [fsc_pkg::ICMP_W-1:0]        icmp_kind,
  input  wire logic [fsc_pkg::ADDR_W-1:0]        source_addr,
  // result port
  output logic                                   alert_strobe,
  output logic      [fsc_pkg::ALERT_KIND_W-1:0]  alert_kind,
  output logic      [fsc_pkg::ADDR_W-1:0]        alert_addr,
  output logic      [fsc_pkg::OUT_COUNT_W-1:0]   alert_count,
  output logic                                   last_alert,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fsc_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [fsc_pkg::PDATA_W-1:0]       pwdata,
  output logic      [fsc_pkg::PDATA_W-1:0]       prdata,
  output logic                                   pready
);

  import fsc_pkg::*;

  logic [LIMIT_W-1:0] syn_limit;
  logic [LIMIT_W-1:0] echo_limit;
  logic               cfg_write;

  // word index sits on the top address bit
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      syn_limit  <= LIMIT_RESET;
      echo_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (paddr[PADDR_W-1])
        REG_SYN_LIMIT:  syn_limit  <= pwdata[LIMIT_W-1:0];
        REG_ECHO_LIMIT: echo_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1])
      REG_SYN_LIMIT:  prdata = PDATA_W'(syn_limit);
      REG_ECHO_LIMIT: prdata = PDATA_W'(echo_limit);
      default:        prdata = '0;
    endcase
  end

  // table of source addresses with used bits
  logic [ADDR_W-1:0]      cam_key;
  cam_alloc_t             cam_alloc;
  logic [SLOT_W-1:0]      cam_rd_slot;
  cam_look_t              cam_look;
  logic                   cam_rd_used;
  logic [ADDR_W-1:0]      cam_rd_addr;

  // tally memories
  ram_req_t               syn_req;
  ram_req_t               echo_req;
  logic [COUNT_WIDTH-1:0] syn_rdata;
  logic [COUNT_WIDTH-1:0] echo_rdata;

  fsc_cam u_cam (
    .clk     (clk),
    .rst     (rst),
    .key     (cam_key),
    .alloc   (cam_alloc),
    .rd_slot (cam_rd_slot),
    .look    (cam_look),
    .rd_used (cam_rd_used),
    .rd_addr (cam_rd_addr)
  );

  fsc_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (COUNT_WIDTH),
    .AW    (SLOT_W)
  ) u_syn_ram (
    .clk   (clk),
    .we    (syn_req.we),
    .waddr (syn_req.waddr),
    .wdata (syn_req.wdata),
    .raddr (syn_req.raddr),
    .rdata (syn_rdata)
  );

  fsc_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (COUNT_WIDTH),
    .AW    (SLOT_W)
  ) u_echo_ram (
    .clk   (clk),
    .we    (echo_req.we),
    .waddr (echo_req.waddr),
    .wdata (echo_req.wdata),
    .raddr (echo_req.raddr),
    .rdata (echo_rdata)
  );

  // control: lookup, read-modify-write, sweep and result staging
  fsc_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .ether_kind    (ether_kind),
    .ip_proto      (ip_proto),
    .tcp_flag_bits (tcp_flag_bits),
    .icmp_kind     (icmp_kind),
    .source_addr   (source_addr),
    .syn_limit     (syn_limit),
    .echo_limit    (echo_limit),
    .alert_strobe  (alert_strobe),
    .alert_kind    (alert_kind),
    .alert_addr    (alert_addr),
    .alert_count   (alert_count),
    .last_alert    (last_alert),
    .cam_key       (cam_key),
    .cam_alloc     (cam_alloc),
    .cam_rd_slot   (cam_rd_slot),
    .cam_look      (cam_look),
    .cam_rd_used   (cam_rd_used),
    .cam_rd_addr   (cam_rd_addr),
    .syn_req       (syn_req),
    .syn_rdata     (syn_rdata),
    .echo_req      (echo_req),
    .echo_rdata    (echo_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fsc_checker.sv =====
`default_nettype none

module fsc_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              command,
  input wire logic                              alert_strobe,
  input wire logic [fsc_pkg::ALERT_KIND_W-1:0]  alert_kind,
  input wire logic [fsc_pkg::OUT_COUNT_W-1:0]   alert_count,
  input wire logic                              last_alert
);

  import fsc_pkg::*;

  // reset leaves the block idle and silent
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !alert_strobe && !busy)
    else $error("result or busy right after reset");

  // a drop is the only result of its packet and carries no count
  a_drop_form: assert property (@(posedge clk) disable iff (rst)
    alert_strobe && (alert_kind == ALERT_DROP) |-> last_alert && (alert_count == '0))
    else $error("drop result malformed");

  // only the three alert codes appear
  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    alert_strobe |-> (alert_kind == ALERT_SYN) || (alert_kind == ALERT_ICMP) ||
                     (alert_kind == ALERT_DROP))
    else $error("unknown alert code");

  // a result that is not the last one comes out during a sweep
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    alert_strobe && !last_alert |-> busy && (alert_kind != ALERT_DROP))
    else $error("non-final result outside a sweep");

  // a taken tick always occupies the block
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command |=> busy)
    else $error("tick taken without going busy");

endmodule

bind per_source_flood_counter_core fsc_checker u_fsc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .command      (command),
  .alert_strobe (alert_strobe),
  .alert_kind   (alert_kind),
  .alert_count  (alert_count),
  .last_alert   (last_alert)
);

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
  import fsc_pkg::*;

  // run limits: even with every item a tick behind the longest idle burst a
  // correct run stays several times under this cap
  localparam int MAX_CYCLES    = 250_000;
  // a tick keeps busy high for its whole table walk and may give no result
  localparam int SETTLE_CYCLES = 2 * TABLE_ENTRIES + 16;
  localparam int POOL_SIZE     = 44;

  // one alert as the block should report it
  typedef struct {
    alert_kind_t            kind;
    logic [ADDR_W-1:0]      addr;
    logic [OUT_COUNT_W-1:0] count;
    logic                   last;
  } alert_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    command = 1'b0;
  logic [KIND_W-1:0]       ether_kind = '0;
  logic [PROTO_W-1:0]      ip_proto = '0;
  logic [FLAG_W-1:0]       tcp_flag_bits = '0;
  logic [ICMP_W-1:0]       icmp_kind = '0;
  logic [ADDR_W-1:0]       source_addr = '0;
  logic                    alert_strobe;
  logic [ALERT_KIND_W-1:0] alert_kind;
  logic [ADDR_W-1:0]       alert_addr;
  logic [OUT_COUNT_W-1:0]  alert_count;
  logic                    last_alert;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [PDATA_W-1:0]      pwdata = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  // alerts still owed by the block, oldest first
  alert_t expected_alerts[$];
  int     fail_count = 0;
  int     cycle_count = 0;

  // shadow of the flood table and the limit registers
  logic [LIMIT_W-1:0]     shadow_syn_limit;
  logic [LIMIT_W-1:0]     shadow_echo_limit;
  logic [ADDR_W-1:0]      slot_addr[TABLE_ENTRIES];
  bit                     slot_used[TABLE_ENTRIES];
  logic [COUNT_WIDTH-1:0] syn_tally[TABLE_ENTRIES];
  logic [COUNT_WIDTH-1:0] echo_tally[TABLE_ENTRIES];

  // addresses the random items draw from; more than the table holds, so it fills
  logic [ADDR_W-1:0]      source_pool[POOL_SIZE];

  per_source_flood_counter_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .ether_kind   (ether_kind),
    .ip_proto     (ip_proto),
    .tcp_flag_bits(tcp_flag_bits),
    .icmp_kind    (icmp_kind),
    .source_addr  (source_addr),
    .alert_strobe (alert_strobe),
    .alert_kind   (alert_kind),
    .alert_addr   (alert_addr),
    .alert_count  (alert_count),
    .last_alert   (last_alert),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk = ~clk;

  // watchdog: a hung block or a lost alert ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // alerts cannot be held off, so each strobe is checked at the edge that ends it
  always @(posedge clk) begin : check_alerts
    alert_t want;
    if (!rst && alert_strobe) begin
      if (expected_alerts.size() == 0) begin
        $error("unexpected alert: kind %0d addr %h count %0d last %0d",
               alert_kind, alert_addr, alert_count, last_alert);
        fail_count++;
      end else begin
        want = expected_alerts.pop_front();
        if (alert_kind !== want.kind) begin
          $error("alert_kind: expected %0d, actual %0d", want.kind, alert_kind);
          fail_count++;
        end
        if (alert_addr !== want.addr) begin
          $error("alert_addr: expected %h, actual %h", want.addr, alert_addr);
          fail_count++;
        end
        if (alert_count !== want.count) begin
          $error("alert_count: expected %0d, actual %0d", want.count, alert_count);
          fail_count++;
        end
        if (last_alert !== want.last) begin
          $error("last_alert: expected %0d, actual %0d", want.last, last_alert);
          fail_count++;
        end
      end
    end
  end

  function automatic void clear_shadow();
    shadow_syn_limit  = LIMIT_RESET;
    shadow_echo_limit = LIMIT_RESET;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_used[i]  = 1'b0;
      slot_addr[i]  = '0;
      syn_tally[i]  = '0;
      echo_tally[i] = '0;
    end
  endfunction

  function automatic int find_slot(input logic [ADDR_W-1:0] addr);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i] && slot_addr[i] == addr) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int lowest_free_slot();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!slot_used[i]) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic alert_t make_alert(input alert_kind_t kind, input logic [ADDR_W-1:0] addr,
                                        input logic [COUNT_WIDTH-1:0] count);
    alert_t a;
    a.kind = kind;
    a.addr = addr;
    // a tally above the output port's maximum is reported as all ones
    if (33'(count) > 33'({OUT_COUNT_W{1'b1}})) begin
      a.count = '1;
    end else begin
      a.count = OUT_COUNT_W'(count);
    end
    a.last = 1'b0;
    return a;
  endfunction

  // works out the alerts of one accepted item and updates the shadow table
  function automatic void predict_alerts(input logic cmd, input logic [KIND_W-1:0] ek,
                                         input logic [PROTO_W-1:0] proto,
                                         input logic [FLAG_W-1:0] flags,
                                         input logic [ICMP_W-1:0] icmp,
                                         input logic [ADDR_W-1:0] src);
    alert_t found[$];
    bit     is_syn;
    bit     is_echo;
    int     slot;
    if (cmd) begin
      // sweep: all syn tallies in slot order, then all echo tallies
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_used[i] && 33'(syn_tally[i]) > 33'(shadow_syn_limit)) begin
          found.push_back(make_alert(ALERT_SYN, slot_addr[i], syn_tally[i]));
          syn_tally[i] = '0;
        end
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_used[i] && 33'(echo_tally[i]) > 33'(shadow_echo_limit)) begin
          found.push_back(make_alert(ALERT_ICMP, slot_addr[i], echo_tally[i]));
          echo_tally[i] = '0;
        end
      end
    end else begin
      is_syn  = ek == IPV4_KIND && proto == TCP_PROTO && (flags & TH_SYN) != '0;
      is_echo = ek == IPV4_KIND && proto == ICMP_PROTO && icmp == ECHO_REQ_KIND;
      if (is_syn || is_echo) begin
        slot = find_slot(src);
        if (slot < 0) begin
          slot = lowest_free_slot();
          if (slot < 0) begin
            // table full: the new source is dropped and nothing is counted
            found.push_back(make_alert(ALERT_DROP, src, '0));
          end else begin
            slot_used[slot]  = 1'b1;
            slot_addr[slot]  = src;
            syn_tally[slot]  = '0;
            echo_tally[slot] = '0;
          end
        end
        if (slot >= 0) begin
          // tallies stick at all ones
          if (is_syn && syn_tally[slot] != '1) begin
            syn_tally[slot] = syn_tally[slot] + 1'b1;
          end
          if (is_echo && echo_tally[slot] != '1) begin
            echo_tally[slot] = echo_tally[slot] + 1'b1;
          end
        end
      end
    end
    if (found.size() > 0) begin
      found[found.size() - 1].last = 1'b1;
    end
    foreach (found[i]) begin
      expected_alerts.push_back(found[i]);
    end
  endfunction

  // drives one item and waits for the edge that takes it; start is left high so
  // that a following item goes out back to back
  task automatic send_item(input logic cmd, input logic [KIND_W-1:0] ek,
                           input logic [PROTO_W-1:0] proto, input logic [FLAG_W-1:0] flags,
                           input logic [ICMP_W-1:0] icmp, input logic [ADDR_W-1:0] src);
    command       <= cmd;
    ether_kind    <= ek;
    ip_proto      <= proto;
    tcp_flag_bits <= flags;
    icmp_kind     <= icmp;
    source_addr   <= src;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    predict_alerts(cmd, ek, proto, flags, icmp, src);
  endtask

  task automatic send_syn(input logic [ADDR_W-1:0] src);
    send_item(1'b0, IPV4_KIND, TCP_PROTO, FLAG_W'($urandom) | TH_SYN,
              ICMP_W'($urandom), src);
  endtask

  task automatic send_echo(input logic [ADDR_W-1:0] src);
    send_item(1'b0, IPV4_KIND, ICMP_PROTO, FLAG_W'($urandom), ECHO_REQ_KIND, src);
  endtask

  // a tick ignores the payload, so it carries junk
  task automatic send_tick();
    send_item(1'b1, KIND_W'($urandom), PROTO_W'($urandom), FLAG_W'($urandom),
              ICMP_W'($urandom), ADDR_W'($urandom));
  endtask

  // packets that are mostly not counted, many of them near misses
  task automatic send_noise(input logic [ADDR_W-1:0] src);
    logic [KIND_W-1:0]  ek;
    logic [PROTO_W-1:0] proto;
    logic [FLAG_W-1:0]  flags;
    logic [ICMP_W-1:0]  icmp;
    ek    = IPV4_KIND;
    proto = PROTO_W'($urandom);
    flags = FLAG_W'($urandom);
    icmp  = ICMP_W'($urandom);
    case ($urandom_range(0, 4))
      0: begin
        ek = KIND_W'($urandom);
      end
      1: begin
        proto = TCP_PROTO;
        flags = flags & ~TH_SYN;
      end
      2: begin
        proto = ICMP_PROTO;
        if (icmp == ECHO_REQ_KIND) begin
          icmp = icmp ^ 8'h01;
        end
      end
      3: begin
        // any other protocol; a tcp or icmp pick here is counted when its flags or kind qualify
      end
      default: begin
        ek    = IPV4_KIND ^ KIND_W'(1 << $urandom_range(0, KIND_W - 1));
        proto = $urandom_range(0, 1) ? TCP_PROTO : ICMP_PROTO;
        flags = flags | TH_SYN;
        icmp  = ECHO_REQ_KIND;
      end
    endcase
    send_item(1'b0, ek, proto, flags, icmp, src);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender pause until every owed alert is in
  task automatic wait_alerts();
    if (expected_alerts.size() != 0) begin
      start <= 1'b0;
      while (expected_alerts.size() != 0) @(posedge clk);
    end
  endtask

  // block fully idle: alerts in, and any quiet tick walked to its end
  task automatic settle();
    wait_alerts();
    hold_off(SETTLE_CYCLES);
  endtask

  // register write: setup cycle, then access until pready
  task automatic write_limit(input reg_idx_t idx, input logic [LIMIT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SYN_LIMIT) begin
      shadow_syn_limit = value;
    end else begin
      shadow_echo_limit = value;
    end
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] syn_value,
                            input logic [LIMIT_W-1:0] echo_value);
    settle();
    write_limit(REG_SYN_LIMIT, syn_value);
    write_limit(REG_ECHO_LIMIT, echo_value);
  endtask

  function automatic logic [ADDR_W-1:0] pick_source();
    if ($urandom_range(0, 19) == 0) begin
      return ADDR_W'($urandom);
    end
    return source_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // reset limits, uncounted packets, field extremes, a quiet tick and the
  // crossing of the reset limit of 100
  task automatic test_directed_basics();
    send_item(1'b0, 16'hFFFF, TCP_PROTO, 8'hFF, 8'hFF, 32'h0A00_0001);
    send_item(1'b0, 16'h0000, ICMP_PROTO, 8'h00, ECHO_REQ_KIND, 32'h0A00_0001);
    send_item(1'b0, IPV4_KIND, TCP_PROTO, 8'hFD, 8'h00, 32'h0A00_0001);
    send_item(1'b0, IPV4_KIND, ICMP_PROTO, 8'hFF, 8'h00, 32'h0A00_0001);
    send_item(1'b0, IPV4_KIND, ICMP_PROTO, 8'h00, 8'hFF, 32'h0A00_0001);
    send_item(1'b0, IPV4_KIND, 8'hFF, 8'hFF, ECHO_REQ_KIND, 32'h0A00_0001);
    send_item(1'b0, IPV4_KIND, 8'h00, 8'hFF, ECHO_REQ_KIND, 32'h0A00_0001);
    send_item(1'b0, IPV4_KIND, TCP_PROTO, TH_SYN, 8'h00, 32'h0000_0000);
    send_item(1'b0, IPV4_KIND, TCP_PROTO, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(1'b0, IPV4_KIND, ICMP_PROTO, 8'h00, ECHO_REQ_KIND, 32'h0000_0000);
    send_item(1'b0, IPV4_KIND, ICMP_PROTO, 8'hFF, ECHO_REQ_KIND, 32'hFFFF_FFFF);
    // quiet tick: nothing above the limit yet
    send_tick();
    hold_off(3);
    // 100 of each is not above the limit, the 101st is
    repeat (100) begin
      send_syn(32'hC0A8_0001);
      send_echo(32'hC0A8_0002);
    end
    send_tick();
    send_syn(32'hC0A8_0001);
    send_echo(32'hC0A8_0002);
    send_tick();
  endtask

  // limits at both ends of their range
  task automatic test_limit_extremes();
    set_limits('0, '0);
    send_syn(32'h0000_0000);
    send_echo(32'hFFFF_FFFF);
    send_syn(32'hC0A8_0002);
    send_tick();
    send_tick();
    set_limits('1, '1);
    send_syn(32'hC0A8_0001);
    send_echo(32'hC0A8_0001);
    send_tick();
  endtask

  // random items: mostly counted packets with ticks, some noise; with_idle gives
  // idle bursts with stretches of none, and now and then the sender drains
  task automatic run_random_items(input int item_total, input bit with_idle);
    int done;
    bit idle_on;
    int pick;
    done    = 0;
    idle_on = 1'b1;
    while (done < item_total) begin
      if (with_idle) begin
        if ($urandom_range(0, 24) == 0) begin
          idle_on = !idle_on;
        end
        if (idle_on && $urandom_range(0, 2) == 0) begin
          hold_off($urandom_range(1, 14));
        end
        if ($urandom_range(0, 79) == 0) begin
          wait_alerts();
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_tick();
        done++;
      end else if (pick < 45) begin
        send_syn(pick_source());
        done++;
      end else if (pick < 80) begin
        send_echo(pick_source());
        done++;
      end else begin
        send_noise(pick_source());
      end
    end
  endtask

  // full table: drops for new sources, then a tick that reports every tally
  task automatic test_full_sweep();
    logic [ADDR_W-1:0] fresh;
    set_limits('0, '0);
    while (lowest_free_slot() >= 0) begin
      fresh = ADDR_W'($urandom);
      send_syn(fresh);
    end
    repeat (2) begin
      do fresh = ADDR_W'($urandom); while (find_slot(fresh) >= 0);
      send_syn(fresh);
      send_echo(fresh);
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      send_syn(slot_addr[i]);
      send_echo(slot_addr[i]);
    end
    send_tick();
  endtask

  initial begin
    clear_shadow();
    source_pool[0] = '0;
    source_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      source_pool[i] = ADDR_W'($urandom);
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_basics();
    test_limit_extremes();
    set_limits(LIMIT_W'($urandom_range(0, 2)), LIMIT_W'($urandom_range(0, 2)));
    run_random_items(36, 1'b1);
    set_limits('0, '1);
    run_random_items(36, 1'b1);
    set_limits('1, '0);
    run_random_items(36, 1'b1);
    test_full_sweep();
    // closing stretch with no idling at all
    set_limits(LIMIT_W'($urandom_range(0, 3)), LIMIT_W'($urandom_range(0, 3)));
    run_random_items(36, 1'b0);

    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_ram.sv
hw/rtl/fsc_cam.sv
hw/rtl/fsc_seq.sv
hw/rtl/per_source_flood_counter_core.sv
hw/rtl/fsc_checker.sv
dv/testbench.sv
